FILE: design/edvr_pkg.sv
// edvr_pkg: shared types and constants for the Euler ZYX rotation block.
// No dependencies.
`default_nettype none

package edvr_pkg;

  typedef struct packed {
    logic signed [15:0] yaw_cdeg;
    logic signed [15:0] pitch_cdeg;
    logic signed [15:0] roll_cdeg;
    logic signed [23:0] body_acc_x;
    logic signed [23:0] body_acc_y;
    logic signed [23:0] body_acc_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] inertial_acc_x;
    logic signed [23:0] inertial_acc_y;
    logic signed [23:0] inertial_acc_z;
  } out_beat_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec_t;

  // Q30 below one, and Q30 up to and including one
  typedef logic [29:0] qfrac_t;
  typedef logic [30:0] qone_t;
  // Q1.15 trig value, +1.0 held as 32768
  typedef logic signed [16:0] trig_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    quad_t quad;
    logic  swap;
  } oct_t;

  localparam qone_t ONE_Q30 = 31'h4000_0000;

  localparam int unsigned DEG_90  = 9000;
  localparam int unsigned DEG_45  = 4500;
  localparam int unsigned DEG_180 = 18000;
  localparam int unsigned DEG_270 = 27000;
  localparam int unsigned DEG_360 = 36000;

  // 2*pi(Q29) = 187403 * 18000 + 5426
  localparam int unsigned PI2_QUO   = 187403;
  localparam int unsigned PI2_REM   = 5426;
  localparam int unsigned RAD_ROUND = 9000;
  localparam int unsigned RAD_SH    = 34;
  localparam int unsigned RAD_RECIP = 954437;  // floor(2^34 / 18000)

  localparam int unsigned SIN_CELLS = 3;
  localparam int unsigned COS_CELLS = 4;
  localparam int unsigned SIN_DIV [SIN_CELLS] = '{42, 20, 6};
  localparam int unsigned COS_DIV [COS_CELLS] = '{56, 30, 12, 2};

  localparam int unsigned TRIG_LAT = 19;
  localparam int unsigned MAT_LAT  = 5;
  localparam int unsigned ACC_DLY  = TRIG_LAT + 3;

  localparam logic signed [23:0] ACC_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] ACC_MIN = -24'sh80_0000;

endpackage

`default_nettype wire

FILE: design/edvr_hstep.sv
// edvr_hstep: one Horner cell, t_out = 1 - floor(((x2 * t_in) >> 30) / DIV).
// Three register stages; x2 travels with the beat. Uses edvr_pkg.
`default_nettype none

module edvr_hstep import edvr_pkg::*; #(
  parameter int unsigned DIV = 2
) (
  input  wire    clk,
  input  wire    en,
  input  qfrac_t x2_in,
  input  qone_t  t_in,
  output qfrac_t x2_out,
  output qone_t  t_out
);

  localparam int unsigned SH = 30 + $clog2(DIV);
  localparam logic [30:0] RECIP = 31'((64'd1 << SH) / DIV);

  logic [60:0] prod_r;
  logic [60:0] qm_r;
  qfrac_t      n_r;
  qfrac_t      x2_a_r, x2_b_r, x2_c_r;
  qone_t       t_r;

  logic [29:0] q0;
  logic [36:0] rem;
  logic [29:0] q_nxt;

  always_comb begin
    q0    = 30'(qm_r >> SH);
    rem   = 37'(n_r) - 37'(q0) * 37'(DIV);
    q_nxt = q0 + 30'(rem >= 37'(DIV));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {31'd0, x2_in} * {30'd0, t_in};
      x2_a_r <= x2_in;
      n_r    <= prod_r[59:30];
      qm_r   <= {31'd0, prod_r[59:30]} * {30'd0, RECIP};
      x2_b_r <= x2_a_r;
      t_r    <= ONE_Q30 - 31'(q_nxt);
      x2_c_r <= x2_b_r;
    end
  end

  assign x2_out = x2_c_r;
  assign t_out  = t_r;

endmodule

`default_nettype wire

FILE: design/edvr_trig.sv
// edvr_trig: sine and cosine of one angle in 0.01 degree, Q1.15 out.
// Octant reduction, radian scaling, then rows of edvr_hstep cells. Uses edvr_pkg.
`default_nettype none

module edvr_trig import edvr_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                vld_in,
  input  wire signed [15:0]  angle,
  output logic               vld_out,
  output trig_t              sin_out,
  output trig_t              cos_out
);

  function automatic logic [16:0] q15(input qone_t v);
    return 17'((32'(v) + 32'd16384) >> 15);
  endfunction

  logic [TRIG_LAT-1:0] vld_r;
  oct_t                oct_r [1:18];
  qfrac_t              x_r   [4:15];
  logic [12:0]         rr_r;
  logic [24:0]         p1_r, p1b_r;
  qfrac_t              base_r, baseb_r;
  logic [44:0]         qm_r;
  logic [59:0]         xx_r;
  qfrac_t              x2_r;
  logic [60:0]         sprod_r;
  qfrac_t              sin_r [17:18];
  trig_t               s_r, c_r;

  // stage 1: octant reduction
  logic signed [17:0] a_ext;
  logic [15:0]        m;
  logic [15:0]        r;
  logic [15:0]        qbase;
  oct_t               oct_nxt;
  logic [12:0]        rr_nxt;

  always_comb begin
    a_ext = 18'(angle);
    m = (a_ext < 0) ? 16'(a_ext + 18'sd36000) : 16'(a_ext);
    if (m >= 16'(DEG_270)) begin
      oct_nxt.quad = QUAD_3;
      qbase = 16'(DEG_270);
    end else if (m >= 16'(DEG_180)) begin
      oct_nxt.quad = QUAD_2;
      qbase = 16'(DEG_180);
    end else if (m >= 16'(DEG_90)) begin
      oct_nxt.quad = QUAD_1;
      qbase = 16'(DEG_90);
    end else begin
      oct_nxt.quad = QUAD_0;
      qbase = 16'd0;
    end
    r = m - qbase;
    oct_nxt.swap = (r > 16'(DEG_45));
    rr_nxt = oct_nxt.swap ? 13'(16'(DEG_90) - r) : 13'(r);
  end

  // stage 4: finish floor(v / 18000)
  logic [10:0] rq0;
  logic [25:0] rrem;
  qfrac_t      x_nxt;

  always_comb begin
    rq0   = 11'(qm_r >> RAD_SH);
    rrem  = 26'(p1b_r) - 26'(rq0) * 26'(DEG_180);
    x_nxt = baseb_r + 30'(rq0) + 30'(rrem >= 26'(DEG_180));
  end

  // cell rows
  qfrac_t cx2 [0:COS_CELLS-1];
  qone_t  ct  [0:COS_CELLS];
  qfrac_t sx2 [0:SIN_CELLS-1];
  qone_t  st  [0:SIN_CELLS];

  assign cx2[0] = x2_r;
  assign ct[0]  = ONE_Q30;
  assign sx2[0] = x2_r;
  assign st[0]  = ONE_Q30;

  genvar gi;
  generate
    for (gi = 0; gi < COS_CELLS; gi++) begin : g_cos
      if (gi == COS_CELLS - 1) begin : g_last
        edvr_hstep #(.DIV(COS_DIV[gi])) u_cell (
          .clk(clk), .en(en), .x2_in(cx2[gi]), .t_in(ct[gi]),
          .x2_out(), .t_out(ct[gi+1]));
      end else begin : g_mid
        edvr_hstep #(.DIV(COS_DIV[gi])) u_cell (
          .clk(clk), .en(en), .x2_in(cx2[gi]), .t_in(ct[gi]),
          .x2_out(cx2[gi+1]), .t_out(ct[gi+1]));
      end
    end
    for (gi = 0; gi < SIN_CELLS; gi++) begin : g_sin
      if (gi == SIN_CELLS - 1) begin : g_last
        edvr_hstep #(.DIV(SIN_DIV[gi])) u_cell (
          .clk(clk), .en(en), .x2_in(sx2[gi]), .t_in(st[gi]),
          .x2_out(), .t_out(st[gi+1]));
      end else begin : g_mid
        edvr_hstep #(.DIV(SIN_DIV[gi])) u_cell (
          .clk(clk), .en(en), .x2_in(sx2[gi]), .t_in(st[gi]),
          .x2_out(sx2[gi+1]), .t_out(st[gi+1]));
      end
    end
  endgenerate

  // final stage: round, swap, quadrant
  trig_t s0, c0, s_nxt, c_nxt;
  qone_t cosv, sinv;

  always_comb begin
    cosv = ct[COS_CELLS];
    sinv = {1'b0, sin_r[18]};
    s0 = signed'(q15(oct_r[18].swap ? cosv : sinv));
    c0 = signed'(q15(oct_r[18].swap ? sinv : cosv));
    case (oct_r[18].quad)
      QUAD_0: begin
        s_nxt = s0;
        c_nxt = c0;
      end
      QUAD_1: begin
        s_nxt = c0;
        c_nxt = -s0;
      end
      QUAD_2: begin
        s_nxt = -s0;
        c_nxt = -c0;
      end
      default: begin
        s_nxt = -c0;
        c_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TRIG_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r     <= rr_nxt;
      oct_r[1] <= oct_nxt;
      for (int k = 2; k <= 18; k++) oct_r[k] <= oct_r[k-1];
      p1_r     <= 25'({12'd0, rr_r} * 25'(PI2_REM) + 25'(RAD_ROUND));
      base_r   <= 30'(30'(rr_r) * 30'(PI2_QUO));
      qm_r     <= 45'(p1_r) * 45'(RAD_RECIP);
      p1b_r    <= p1_r;
      baseb_r  <= base_r;
      x_r[4]   <= x_nxt;
      for (int k = 5; k <= 15; k++) x_r[k] <= x_r[k-1];
      xx_r     <= 60'(x_r[4]) * 60'(x_r[4]);
      x2_r     <= 30'((xx_r + 60'(64'd1 << 29)) >> 30);
      sprod_r  <= {31'd0, x_r[15]} * {30'd0, st[SIN_CELLS]};
      sin_r[17] <= sprod_r[59:30];
      sin_r[18] <= sin_r[17];
      s_r      <= s_nxt;
      c_r      <= c_nxt;
    end
  end

  assign vld_out = vld_r[TRIG_LAT-1];
  assign sin_out = s_r;
  assign cos_out = c_r;

endmodule

`default_nettype wire

FILE: design/euler_dcm_vector_rotate.sv
// euler_dcm_vector_rotate: rotates a body-frame acceleration into the inertial
// frame through the ZYX direction cosine matrix. Uses edvr_pkg, edvr_trig.
//
// Usage:
//   Input beat (in_valid/in_ready/in_data): yaw, pitch, roll in 0.01 degree
//   and a Q7.16 body acceleration vector. Output beat (out_valid/out_ready/
//   out_data): the Q7.16 inertial vector, each component saturated.
//   Throughput: one beat per cycle while the output is not stalled; the
//   trig rows of Horner cells, the 14 matrix-entry multipliers and 9 vector
//   multipliers are all fully pipelined, so nothing is shared between beats.
//   Stall: the whole pipeline moves on one enable. While out_valid is high
//   and out_ready low the pipeline freezes and in_ready is low; in_ready
//   is high whenever the output register is empty or being taken.
//   Reset (rst_n low, synchronous): all valid bits clear, out_valid drops;
//   no beat is lost or produced by reset besides discarding those in flight.
`default_nettype none

module euler_dcm_vector_rotate import edvr_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_beat_t out_data
);

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic  vld_y, vld_p, vld_r_unused_guard;
  trig_t sy, cy, sp, cp, sr, cr;

  edvr_trig u_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
    .angle(in_data.yaw_cdeg), .vld_out(vld_y), .sin_out(sy), .cos_out(cy));
  edvr_trig u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
    .angle(in_data.pitch_cdeg), .vld_out(vld_p), .sin_out(sp), .cos_out(cp));
  edvr_trig u_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
    .angle(in_data.roll_cdeg), .vld_out(vld_r_unused_guard),
    .sin_out(sr), .cos_out(cr));

  // acceleration rides alongside the trig rows
  vec_t acc_d [1:ACC_DLY];

  // stage 20: pair products (Q30)
  logic signed [33:0] cpcy_r, cpsy_r, crsy_r, srsy_r, crcy_r, srcy_r;
  logic signed [33:0] srsp_r, crsp_r, srcp_r, crcp_r, d20_r;
  trig_t              cy_r, sy_r;
  // stage 21: triple products (Q45) and delayed pairs
  logic signed [50:0] sspc_r, ssps_r, cspc_r, csps_r;
  logic signed [33:0] cpcy2_r, cpsy2_r, crsy2_r, srsy2_r, crcy2_r, srcy2_r;
  logic signed [33:0] srcp2_r, crcp2_r, d202_r;
  // stage 22: matrix entries (Q30)
  logic signed [32:0] d_r [3][3];
  // stage 23: entry times component
  logic signed [56:0] pr_r [3][3];
  // stage 24: row sums
  logic signed [58:0] sum_r [3];
  logic [MAT_LAT-1:0] vm_r;
  logic signed [23:0] res_r [3];

  function automatic logic signed [32:0] rnd15(input logic signed [51:0] v);
    return 33'((v + 52'sd16384) >>> 15);
  endfunction

  logic signed [32:0] d01_nxt, d02_nxt, d11_nxt, d12_nxt;

  always_comb begin
    d01_nxt = rnd15(-(52'(crsy2_r) <<< 15) + 52'(sspc_r));
    d02_nxt = rnd15((52'(srsy2_r) <<< 15) + 52'(cspc_r));
    d11_nxt = rnd15((52'(crcy2_r) <<< 15) + 52'(ssps_r));
    d12_nxt = rnd15(-(52'(srcy2_r) <<< 15) + 52'(csps_r));
  end

  logic signed [28:0] rv [3];
  logic signed [23:0] res_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv[i] = 29'((sum_r[i] + 59'sd536870912) >>> 30);
      if (rv[i] > 29'(ACC_MAX)) begin
        res_nxt[i] = ACC_MAX;
      end else if (rv[i] < 29'(ACC_MIN)) begin
        res_nxt[i] = ACC_MIN;
      end else begin
        res_nxt[i] = 24'(rv[i]);
      end
    end
  end

  logic signed [23:0] accv [3];

  always_comb begin
    accv[0] = acc_d[ACC_DLY].x;
    accv[1] = acc_d[ACC_DLY].y;
    accv[2] = acc_d[ACC_DLY].z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vm_r        <= {vm_r[MAT_LAT-2:0], vld_y};
      out_valid_r <= vm_r[MAT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_d[1] <= '{x: in_data.body_acc_x, y: in_data.body_acc_y,
                    z: in_data.body_acc_z};
      for (int k = 2; k <= ACC_DLY; k++) acc_d[k] <= acc_d[k-1];

      cpcy_r <= 34'(cp) * 34'(cy);
      cpsy_r <= 34'(cp) * 34'(sy);
      crsy_r <= 34'(cr) * 34'(sy);
      srsy_r <= 34'(sr) * 34'(sy);
      crcy_r <= 34'(cr) * 34'(cy);
      srcy_r <= 34'(sr) * 34'(cy);
      srsp_r <= 34'(sr) * 34'(sp);
      crsp_r <= 34'(cr) * 34'(sp);
      srcp_r <= 34'(sr) * 34'(cp);
      crcp_r <= 34'(cr) * 34'(cp);
      d20_r  <= -(34'(sp) <<< 15);
      cy_r   <= cy;
      sy_r   <= sy;

      sspc_r  <= 51'(srsp_r) * 51'(cy_r);
      ssps_r  <= 51'(srsp_r) * 51'(sy_r);
      cspc_r  <= 51'(crsp_r) * 51'(cy_r);
      csps_r  <= 51'(crsp_r) * 51'(sy_r);
      cpcy2_r <= cpcy_r;
      cpsy2_r <= cpsy_r;
      crsy2_r <= crsy_r;
      srsy2_r <= srsy_r;
      crcy2_r <= crcy_r;
      srcy2_r <= srcy_r;
      srcp2_r <= srcp_r;
      crcp2_r <= crcp_r;
      d202_r  <= d20_r;

      d_r[0][0] <= 33'(cpcy2_r);
      d_r[0][1] <= d01_nxt;
      d_r[0][2] <= d02_nxt;
      d_r[1][0] <= 33'(cpsy2_r);
      d_r[1][1] <= d11_nxt;
      d_r[1][2] <= d12_nxt;
      d_r[2][0] <= 33'(d202_r);
      d_r[2][1] <= 33'(srcp2_r);
      d_r[2][2] <= 33'(crcp2_r);

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= 57'(d_r[i][j]) * 57'(accv[j]);
        end
      end

      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= 59'(pr_r[i][0]) + 59'(pr_r[i][1]) + 59'(pr_r[i][2]);
      end

      for (int i = 0; i < 3; i++) res_r[i] <= res_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = '{inertial_acc_x: res_r[0], inertial_acc_y: res_r[1],
                       inertial_acc_z: res_r[2]};

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vm_r) && $stable(out_valid_r))
    else $error("matrix pipeline moved while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && vm_r == '0)
    else $error("valid bits not cleared by reset");

  a_trig_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    vld_y == vld_p && vld_p == vld_r_unused_guard)
    else $error("trig lanes out of step");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_y |-> (sy <= 17'sd32768 && sy >= -17'sd32768 &&
               cp <= 17'sd32768 && cp >= -17'sd32768 &&
               cr <= 17'sd32768 && cr >= -17'sd32768))
    else $error("trig value out of range");

endmodule

`default_nettype wire

FILE: sim/euler_dcm_vector_rotate_tb.sv
// euler_dcm_vector_rotate_tb: predicts the ZYX direction cosine rotation of
// each accepted beat and checks every output beat field by field.
// Depends on edvr_pkg and euler_dcm_vector_rotate.
`timescale 1ns / 100ps

module euler_dcm_vector_rotate_tb import edvr_pkg::*; ();

  class rotation_scoreboard;
    out_beat_t pending[$];
    int errors;

    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint unsigned to_rad(int unsigned r);
      return (longint'(r) * 64'd1686629713 * 2 + 9000) / 18000;
    endfunction

    function longint unsigned oct_sin(int unsigned r);
      longint unsigned x, x2, t;
      x = to_rad(r);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t = (64'd1 << 30) - x2 / 42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
    endfunction

    function longint unsigned oct_cos(int unsigned r);
      longint unsigned x, x2, t;
      x = to_rad(r);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t = (64'd1 << 30) - x2 / 56;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      return (64'd1 << 30) - ((x2 * t) >> 30) / 2;
    endfunction

    function void sin_cos(logic signed [15:0] a, output longint s, output longint c);
      longint m, s0, c0;
      int unsigned q, r;
      m = ((longint'(a) % 36000) + 36000) % 36000;
      q = 32'(m / 9000);
      r = 32'(m % 9000);
      if (r <= 4500) begin
        s0 = (oct_sin(r) + (1 << 14)) >> 15;
        c0 = (oct_cos(r) + (1 << 14)) >> 15;
      end else begin
        s0 = (oct_cos(9000 - r) + (1 << 14)) >> 15;
        c0 = (oct_sin(9000 - r) + (1 << 14)) >> 15;
      end
      case (q)
        0: begin s = s0; c = c0; end
        1: begin s = c0; c = -s0; end
        2: begin s = -s0; c = -c0; end
        default: begin s = -c0; c = s0; end
      endcase
    endfunction

    function void note_input(in_beat_t b);
      longint sy, cy, sp, cp, sr, cr, sum;
      longint d[3][3];
      longint v[3];
      out_beat_t o;
      logic signed [23:0] res[3];
      sin_cos(b.yaw_cdeg, sy, cy);
      sin_cos(b.pitch_cdeg, sp, cp);
      sin_cos(b.roll_cdeg, sr, cr);
      v[0] = b.body_acc_x; v[1] = b.body_acc_y; v[2] = b.body_acc_z;
      d[0][0] = rnd_shift(cp * cy * 32768, 15);
      d[0][1] = rnd_shift(-cr * sy * 32768 + sr * sp * cy, 15);
      d[0][2] = rnd_shift(sr * sy * 32768 + cr * sp * cy, 15);
      d[1][0] = rnd_shift(cp * sy * 32768, 15);
      d[1][1] = rnd_shift(cr * cy * 32768 + sr * sp * sy, 15);
      d[1][2] = rnd_shift(-sr * cy * 32768 + cr * sp * sy, 15);
      d[2][0] = -sp * 32768;
      d[2][1] = sr * cp;
      d[2][2] = cr * cp;
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int j = 0; j < 3; j++) sum += d[i][j] * v[j];
        sum = rnd_shift(sum, 30);
        if (sum > 8388607) sum = 8388607;
        if (sum < -8388608) sum = -8388608;
        res[i] = sum[23:0];
      end
      o.inertial_acc_x = res[0];
      o.inertial_acc_y = res[1];
      o.inertial_acc_z = res[2];
      pending.push_back(o);
    endfunction

    function void check_output(out_beat_t got);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("output beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.inertial_acc_x !== e.inertial_acc_x) begin
        $error("inertial_acc_x exp %0d got %0d", e.inertial_acc_x, got.inertial_acc_x);
        errors++;
      end
      if (got.inertial_acc_y !== e.inertial_acc_y) begin
        $error("inertial_acc_y exp %0d got %0d", e.inertial_acc_y, got.inertial_acc_y);
        errors++;
      end
      if (got.inertial_acc_z !== e.inertial_acc_z) begin
        $error("inertial_acc_z exp %0d got %0d", e.inertial_acc_z, got.inertial_acc_z);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  rotation_scoreboard sb = new();
  in_beat_t stim[$];
  bit feed_done = 1'b0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  euler_dcm_vector_rotate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** euler_dcm_vector_rotate: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return 16'($signed(9000 * $urandom_range(0, 4)) - 18000);
      2: return 16'($signed(4500 * $urandom_range(0, 8)) - 18000
               + $signed($urandom_range(0, 2)) - 1);
      default: return 16'($signed($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_acc();
    case ($urandom_range(0, 7))
      0: return 24'($urandom());
      1: return $urandom_range(0, 1) ? ACC_MAX : ACC_MIN;
      default: return 24'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
    endcase
  endfunction

  task automatic build_directed();
    in_beat_t b;
    logic signed [15:0] angs[9] = '{0, 9000, -9000, 18000, -18000, 4500, 4501,
                                    16'sh7FFF, 16'sh8000};
    foreach (angs[i]) begin
      b.yaw_cdeg = angs[i];
      b.pitch_cdeg = angs[(i + 3) % 9];
      b.roll_cdeg = angs[(i + 6) % 9];
      b.body_acc_x = (i % 2) ? ACC_MAX : ACC_MIN;
      b.body_acc_y = (i % 3) ? ACC_MIN : ACC_MAX;
      b.body_acc_z = 24'(65536 * (i - 4));
      stim.push_back(b);
    end
    for (int i = 0; i < 8; i++) begin
      b.yaw_cdeg = 16'(4500 * i - 18000 + 4500);
      b.pitch_cdeg = 16'(4500 * i);
      b.roll_cdeg = 16'(-4500 * i);
      b.body_acc_x = ACC_MAX;
      b.body_acc_y = ACC_MAX;
      b.body_acc_z = ACC_MAX;
      stim.push_back(b);
    end
  endtask

  task automatic send_beats();
    int n;
    build_directed();
    for (int i = 0; i < 1700; i++)
      stim.push_back(in_beat_t'{pick_angle(), pick_angle(), pick_angle(),
                                pick_acc(), pick_acc(), pick_acc()});
    while (stim.size() > 0) begin
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= stim.pop_front();
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;
  endtask

  task automatic take_beats();
    int n;
    forever begin
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      send_beats();
      take_beats();
    join_none
    wait (feed_done);
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** euler_dcm_vector_rotate: PASSED **");
    end else begin
      $display("** euler_dcm_vector_rotate: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/edvr_pkg.sv
design/edvr_hstep.sv
design/edvr_trig.sv
design/euler_dcm_vector_rotate.sv
sim/euler_dcm_vector_rotate_tb.sv
